[rtl/rac_pkg.sv]
// shared types and constants for the range align-and-coalesce block
// no dependencies
package rac_pkg;
  localparam int MaxRanges = 64;
  localparam int IdxW = $clog2(MaxRanges);
  localparam int CntW = IdxW + 1;
  localparam int AddrW = 49;
  localparam int QuoW = 50;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_MUL,
    ST_STORE,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             shift;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] stop;
  } cell_ctl_t;
endpackage

[rtl/range_align_and_coalesce_core.sv]
// top level of the range align-and-coalesce block
// depends on rac_pkg, rac_divider, rac_cell
//
// usage: raise start with range_offset, range_size, batch_last while busy is
// low; the transfer happens at that rising edge. each nonzero range is aligned
// by two passes of a 50-bit restoring divider (one quotient bit per cycle); the
// remainders give the rounded bounds. busy stays high until the range is stored,
// so the next item can follow only once the previous one is stored; zero-size
// items that are not last keep busy low and the next item can follow at once.
// aligned ranges drop into a chain of 64 cells that keeps them sorted by start.
// on the last item, after the sort state the chain shifts toward the head one
// cell per cycle and merged ranges leave on merged_start/merged_length with
// result_valid high for one cycle each; result_last marks the final one.
// an empty batch gives one result with batch_empty set, registered in the
// sort state that directly follows the transfer.
// the receiver cannot stall: results are fire and forget.
// align_bytes is written through cfg_valid/cfg_ready while busy is low;
// zero acts as one. reset clears the chain, the counters and sets align to one.
module range_align_and_coalesce_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [47:0] range_offset,
  input  logic [39:0] range_size,
  input  logic        batch_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [48:0] merged_start,
  output logic [48:0] merged_length,
  output logic        result_last,
  output logic        batch_empty,
  output logic        store_overflow
);
  localparam int N = rac_pkg::MaxRanges;
  localparam int W = rac_pkg::AddrW;

  rac_pkg::state_t state, state_next;

  logic [31:0]                align_bytes;
  logic [31:0]                al;
  logic [47:0]                off;
  logic [W-1:0]               fin;
  logic                       last_q;
  logic [rac_pkg::CntW-1:0]   count;
  logic                       overflow_seen;
  logic [31:0]                r_lo, r_hi;
  logic [rac_pkg::QuoW-1:0]   hi_num;
  logic [W-1:0]               new_start, new_stop;
  logic [W-1:0]               cur_s, cur_e;
  logic                       have_cur;
  logic                       div_go, div_done;
  logic [rac_pkg::QuoW-1:0]   div_in;
  logic [31:0]                div_r;
  rac_pkg::cell_ctl_t         ctl;
  logic [N:0]                 c_valid;
  logic [N-1:0]               c_gt;
  logic [W-1:0]               c_start [N+1];
  logic [W-1:0]               c_stop [N+1];

  assign al        = (align_bytes == 32'd0) ? 32'd1 : align_bytes;
  assign busy      = (state != rac_pkg::ST_IDLE);
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      align_bytes <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      align_bytes <= cfg_data;
    end
  end

  // dividend for the low pass is the offset, for the high pass end + al - 1
  assign hi_num = rac_pkg::QuoW'(fin) + rac_pkg::QuoW'(al) - rac_pkg::QuoW'(1);
  assign div_in = (state == rac_pkg::ST_IDLE) ? rac_pkg::QuoW'(range_offset) : hi_num;

  always_comb begin
    div_go = 1'b0;
    if (state == rac_pkg::ST_IDLE && start && range_size != '0) div_go = 1'b1;
    if (state == rac_pkg::ST_DIV_LO && div_done) div_go = 1'b1;
  end

  rac_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_in),
    .divisor(al), .done(div_done), .remainder(div_r)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rac_pkg::ST_IDLE: begin
        if (start) begin
          if (range_size != '0) state_next = rac_pkg::ST_DIV_LO;
          else if (batch_last)  state_next = rac_pkg::ST_SORT;
        end
      end
      rac_pkg::ST_DIV_LO: if (div_done) state_next = rac_pkg::ST_DIV_HI;
      rac_pkg::ST_DIV_HI: if (div_done) state_next = rac_pkg::ST_MUL;
      rac_pkg::ST_MUL:    state_next = rac_pkg::ST_STORE;
      rac_pkg::ST_STORE:  state_next = last_q ? rac_pkg::ST_SORT : rac_pkg::ST_IDLE;
      rac_pkg::ST_SORT:   state_next = (count == '0) ? rac_pkg::ST_IDLE : rac_pkg::ST_EMIT;
      rac_pkg::ST_EMIT:   if (!c_valid[0]) state_next = rac_pkg::ST_IDLE;
      default:            state_next = rac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    ctl.start = new_start;
    ctl.stop  = new_stop;
    unique case (state)
      rac_pkg::ST_STORE: ctl.load  = (count < rac_pkg::CntW'(N));
      rac_pkg::ST_EMIT:  ctl.shift = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rac_pkg::ST_IDLE;
      count         <= '0;
      overflow_seen <= 1'b0;
      have_cur      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      unique case (state)
        rac_pkg::ST_IDLE: begin
          if (start) begin
            off    <= range_offset;
            fin    <= W'(range_offset) + W'(range_size);
            last_q <= batch_last;
            if (range_size != '0 && count == rac_pkg::CntW'(N)) overflow_seen <= 1'b1;
          end
        end
        rac_pkg::ST_DIV_LO: if (div_done) r_lo <= div_r;
        rac_pkg::ST_DIV_HI: if (div_done) r_hi <= div_r;
        rac_pkg::ST_MUL: begin
          // round down / up by dropping the remainder
          new_start <= W'(off) - W'(r_lo);
          new_stop  <= W'(hi_num - rac_pkg::QuoW'(r_hi));
        end
        rac_pkg::ST_STORE: begin
          if (count < rac_pkg::CntW'(N)) count <= count + rac_pkg::CntW'(1);
        end
        rac_pkg::ST_SORT: begin
          have_cur <= 1'b0;
          if (count == '0) begin
            result_valid   <= 1'b1;
            merged_start   <= '0;
            merged_length  <= '0;
            result_last    <= 1'b0;
            batch_empty    <= 1'b1;
            store_overflow <= 1'b0;
            overflow_seen  <= 1'b0;
          end
        end
        rac_pkg::ST_EMIT: begin
          batch_empty    <= 1'b0;
          store_overflow <= overflow_seen;
          if (c_valid[0]) begin
            if (!have_cur) begin
              have_cur <= 1'b1;
              cur_s    <= c_start[0];
              cur_e    <= c_stop[0];
            end else if (c_start[0] <= cur_e) begin
              if (c_stop[0] > cur_e) cur_e <= c_stop[0];
            end else begin
              result_valid  <= 1'b1;
              merged_start  <= cur_s;
              merged_length <= cur_e - cur_s;
              result_last   <= 1'b0;
              cur_s         <= c_start[0];
              cur_e         <= c_stop[0];
            end
          end else begin
            // chain drained: flush the open range as the final result
            result_valid  <= 1'b1;
            merged_start  <= cur_s;
            merged_length <= cur_e - cur_s;
            result_last   <= 1'b1;
            have_cur      <= 1'b0;
            count         <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // cell 0 is the head; the incoming range inserts at the first open cell
  assign c_valid[N] = 1'b0;
  assign c_start[N] = '0;
  assign c_stop[N]  = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] ps, pe;
    logic         pv, pg;
    // loading shifts right from cell i-1; emitting shifts left from cell i+1
    if (i == 0) begin : g_head
      // while loading the head sees an occupied, lower slot on its left
      assign ps = ctl.shift ? c_start[1] : '0;
      assign pe = ctl.shift ? c_stop[1]  : '0;
      assign pv = ctl.shift ? c_valid[1] : 1'b1;
      assign pg = 1'b0;
    end else begin : g_body
      assign ps = ctl.shift ? c_start[i+1] : c_start[i-1];
      assign pe = ctl.shift ? c_stop[i+1]  : c_stop[i-1];
      assign pv = ctl.shift ? c_valid[i+1] : c_valid[i-1];
      assign pg = c_gt[i-1];
    end
    rac_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .prev_valid(pv), .prev_gt(pg),
      .prev_start(ps), .prev_stop(pe),
      .valid(c_valid[i]), .gt(c_gt[i]),
      .start(c_start[i]), .stop(c_stop[i])
    );
  end
endmodule

[rtl/rac_divider.sv]
// restoring divider, one quotient bit per cycle; gives the remainder
// depends on rac_pkg
module rac_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [rac_pkg::QuoW-1:0]    dividend,
  input  logic [31:0]                 divisor,
  output logic                        done,
  output logic [31:0]                 remainder
);
  logic [rac_pkg::QuoW-1:0] quo;
  logic [32:0]              rem;
  logic [31:0]              dvs;
  logic [5:0]               cnt;
  logic                     busy;
  logic [33:0]              trial;

  assign trial = {rem, quo[rac_pkg::QuoW-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= 6'(rac_pkg::QuoW);
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quo <= {quo[rac_pkg::QuoW-2:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[rac_pkg::QuoW-1]};
          quo <= {quo[rac_pkg::QuoW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // the remainder is below the divisor, so 32 bits hold it
  assign remainder = rem[31:0];
endmodule

[rtl/rac_cell.sv]
// one slot of the insertion-sort chain: holds a range and its valid bit
// depends on rac_pkg
module rac_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  rac_pkg::cell_ctl_t        ctl,
  // neighbor feeding this slot: the left one on load, the right one on shift
  input  logic                      prev_valid,
  input  logic                      prev_gt,
  input  logic [rac_pkg::AddrW-1:0] prev_start,
  input  logic [rac_pkg::AddrW-1:0] prev_stop,
  output logic                      valid,
  output logic                      gt,
  output logic [rac_pkg::AddrW-1:0] start,
  output logic [rac_pkg::AddrW-1:0] stop
);
  logic open_here;
  logic open_prev;

  // gt: this slot holds a range ordered after the incoming one
  assign gt = valid && (start > ctl.start);
  // open: empty or ordered after the incoming range; the first open slot takes it
  assign open_here = !valid || gt;
  assign open_prev = !prev_valid || prev_gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= prev_valid;
    end else if (ctl.load) begin
      if (prev_gt || (open_here && !open_prev)) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      start <= prev_start;
      stop  <= prev_stop;
    end else if (ctl.load) begin
      if (prev_gt) begin
        start <= prev_start;
        stop  <= prev_stop;
      end else if (open_here && !open_prev) begin
        start <= ctl.start;
        stop  <= ctl.stop;
      end
    end
  end
endmodule
